### hdl/usc_pkg.sv
// Constants, types and the month table for the seconds-to-calendar pipeline.
package usc_pkg;

  // Seconds in a day, an hour and a minute.
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;

  // Day count: the low seven bits of the seconds are dropped (86400 = 128 * 675).
  localparam int unsigned DayShift  = 7;
  localparam int unsigned DayDivOdd = SecsPerDay >> DayShift;
  localparam int unsigned DayRecipK = 25;
  localparam int unsigned DayRecip  = (1 << DayRecipK) / DayDivOdd;

  // Civil day number of the epoch and the Gregorian correction.
  localparam int unsigned EpochDay    = 2440588;
  localparam int unsigned AlphaNum    = 7468865;
  localparam int unsigned AlphaDen    = 146097;
  localparam int unsigned WOffset     = 4 * EpochDay - AlphaNum;
  localparam int unsigned AlphaBase   = 15;
  localparam int unsigned AlphaStep1  = (AlphaBase + 1) * AlphaDen;
  localparam int unsigned AlphaStep2  = (AlphaBase + 2) * AlphaDen;
  localparam int unsigned BOffset     = EpochDay + 1 + 1524;

  // Year count c = floor((20b - 2442) / 7305).
  localparam int unsigned CSub     = 2442;
  localparam int unsigned CDen     = 7305;
  localparam int unsigned CRecipK  = 26;
  localparam int unsigned CRecip   = (1 << CRecipK) / CDen;

  // Month count e = floor(10000 (b - d) / 306001).
  localparam int unsigned EScale   = 10000;
  localparam int unsigned EDen     = 306001;
  localparam int unsigned ERecipK  = 24;
  localparam int unsigned ERecip   = (1 << ERecipK) / EDen;

  // Hour and minute reciprocals.
  localparam int unsigned HourRecipK = 17;
  localparam int unsigned HourRecip  = (1 << HourRecipK) / SecsPerHour;
  localparam int unsigned MinRecipK  = 12;
  localparam int unsigned MinRecip   = (1 << MinRecipK) / SecsPerMin;

  localparam int unsigned YearOffsetLate  = 4716;
  localparam int unsigned YearOffsetEarly = 4715;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // floor(30.6001 * e): the first day of the March-based month e, less one.
  function automatic logic [8:0] month_base(input logic [3:0] e);
    logic [8:0] base;
    begin
      case (e)
        4'd4:    base = 9'd122;
        4'd5:    base = 9'd153;
        4'd6:    base = 9'd183;
        4'd7:    base = 9'd214;
        4'd8:    base = 9'd244;
        4'd9:    base = 9'd275;
        4'd10:   base = 9'd306;
        4'd11:   base = 9'd336;
        4'd12:   base = 9'd367;
        4'd13:   base = 9'd397;
        4'd14:   base = 9'd428;
        4'd15:   base = 9'd459;
        default: base = 9'd0;
      endcase
      return base;
    end
  endfunction

endpackage

### hdl/unix_seconds_to_calendar.sv
// Pipelined conversion of Unix seconds to Gregorian date and time of day.
// The result appears on the ports when the request's valid bit leaves the end of the valid shift register.
// Throughput: one request per cycle; the pipeline never stalls, so busy stays low.
// The length is set by the chain of constant-reciprocal divisions, each spread over a multiply stage,
// a remainder stage and a compare-and-correct stage (the minute division merges the last two).
// Reset clears the valid bits only; data registers are not reset.
module unix_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_unix_seconds,
  output logic        out_valid,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);
  import usc_pkg::*;

  localparam int NStg    = 15;
  localparam int NTmDly  = 6;

  logic [NStg-1:0] vld_r, vld_nxt;

  // Stage 1..4: days and seconds of the day.
  logic [31:0] secs_s1_r, secs_s2_r, secs_s3_r;
  logic [15:0] dq_s2_r, dq_s3_r, days_s4_r;
  logic [32:0] dp_s3_r;
  logic [16:0] tod_s4_r, tod_s5_r;

  // Stage 5..15: date.
  logic [21:0] b_s5_r, b_s6_r, b_s7_r, b_s8_r, b_s9_r;
  logic [25:0] y_s6_r, y_s7_r;
  logic [12:0] cq_s7_r, cq_s8_r, c_s9_r, c_s10_r, c_s11_r, c_s12_r, c_s13_r, c_s14_r;
  logic [13:0] cr_s8_r;
  logic [9:0]  bd_s10_r, bd_s11_r, bd_s12_r, bd_s13_r, bd_s14_r;
  logic [23:0] v_s11_r, v_s12_r;
  logic [3:0]  eq_s12_r, eq_s13_r, e_s14_r;
  logic [19:0] er_s13_r;

  // Stage 5..9: time of day, then a delay line up to the output stage.
  logic [4:0]  hq_s5_r, hq_s6_r, hour_s7_r, hour_s8_r;
  logic [12:0] hr_s6_r;
  logic [11:0] rem_s7_r, rem_s8_r;
  logic [5:0]  mq_s8_r;
  tod_t        tm_r [NTmDly];

  // Combinational values.
  logic [40:0] dq_prod;
  logic [32:0] drem;
  logic        dge;
  logic [21:0] w;
  logic [4:0]  alpha;
  logic [4:0]  alpha_adj;
  logic [22:0] hq_prod;
  logic [39:0] cq_prod;
  logic [25:0] cr_full;
  logic [12:0] hr_nxt;
  logic        hge;
  logic [18:0] mq_prod;
  logic [11:0] mr_full;
  logic        mge;
  logic [23:0] d_prod;
  logic [21:0] bd_full;
  logic [29:0] eq_prod;
  logic [23:0] er_full;
  logic [3:0]  mon_nxt;
  logic [4:0]  dom_nxt;
  logic [11:0] year_nxt;
  tod_t        tm_nxt;

  assign busy = 1'b0;

  always_comb begin
    vld_nxt = {vld_r[NStg-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    dq_prod   = 41'(secs_s1_r[31:DayShift]) * 41'(DayRecip);
    drem      = {1'b0, secs_s3_r} - dp_s3_r;
    dge       = drem[17:0] >= 18'(SecsPerDay);

    w         = 22'({days_s4_r, 2'b00}) + 22'(WOffset);
    alpha     = 5'(AlphaBase) + 5'(w >= 22'(AlphaStep1)) + 5'(w >= 22'(AlphaStep2));
    alpha_adj = alpha - (alpha >> 2);
    hq_prod   = 23'(tod_s4_r) * 23'(HourRecip);

    hr_nxt    = 13'(tod_s5_r - 17'(17'(hq_s5_r) * 17'(SecsPerHour)));

    cq_prod   = 40'(y_s6_r) * 40'(CRecip);
    hge       = hr_s6_r >= 13'(SecsPerHour);

    cr_full   = y_s7_r - 26'(26'(cq_s7_r) * 26'(CDen));
    mq_prod   = 19'(rem_s7_r) * 19'(MinRecip);

    mr_full   = rem_s8_r - 12'(12'(mq_s8_r) * 12'(SecsPerMin));
    mge       = mr_full >= 12'(SecsPerMin);
    tm_nxt.hour   = hour_s8_r;
    tm_nxt.minute = mq_s8_r + 6'(mge);
    tm_nxt.second = mge ? 6'(mr_full - 12'(SecsPerMin)) : 6'(mr_full);

    d_prod    = 24'(c_s9_r) * 24'd1461;
    bd_full   = b_s9_r - d_prod[23:2];

    eq_prod   = 30'(v_s11_r) * 30'(ERecip);
    er_full   = v_s12_r - 24'(24'(eq_s12_r) * 24'(EDen));

    // The month count runs from March; January and February close the year before.
    mon_nxt   = (e_s14_r < 4'd14) ? e_s14_r - 4'd1 : e_s14_r - 4'd13;
    dom_nxt   = 5'(bd_s14_r - 10'(month_base(e_s14_r)));
    year_nxt  = (mon_nxt > 4'd2) ? 12'(c_s14_r - 13'(YearOffsetLate))
                                 : 12'(c_s14_r - 13'(YearOffsetEarly));
  end

  always_ff @(posedge clk) begin
    secs_s1_r <= in_unix_seconds;

    dq_s2_r   <= dq_prod[40:25];
    secs_s2_r <= secs_s1_r;

    dp_s3_r   <= 33'(dq_s2_r) * 33'(SecsPerDay);
    dq_s3_r   <= dq_s2_r;
    secs_s3_r <= secs_s2_r;

    // The reciprocal estimate may be one short; one compare puts it right.
    days_s4_r <= dq_s3_r + 16'(dge);
    tod_s4_r  <= dge ? 17'(drem - 33'(SecsPerDay)) : 17'(drem);

    b_s5_r    <= 22'(days_s4_r) + 22'(BOffset) + 22'(alpha_adj);
    hq_s5_r   <= hq_prod[21:17];
    tod_s5_r  <= tod_s4_r;

    y_s6_r    <= 26'(b_s5_r) * 26'd20 - 26'(CSub);
    b_s6_r    <= b_s5_r;
    hr_s6_r   <= hr_nxt;
    hq_s6_r   <= hq_s5_r;

    cq_s7_r   <= cq_prod[38:26];
    y_s7_r    <= y_s6_r;
    b_s7_r    <= b_s6_r;
    hour_s7_r <= hq_s6_r + 5'(hge);
    rem_s7_r  <= hge ? 12'(hr_s6_r - 13'(SecsPerHour)) : 12'(hr_s6_r);

    cr_s8_r   <= cr_full[13:0];
    cq_s8_r   <= cq_s7_r;
    b_s8_r    <= b_s7_r;
    mq_s8_r   <= mq_prod[17:12];
    rem_s8_r  <= rem_s7_r;
    hour_s8_r <= hour_s7_r;

    c_s9_r    <= cq_s8_r + 13'(cr_s8_r >= 14'(CDen));
    b_s9_r    <= b_s8_r;
    tm_r[0]   <= tm_nxt;
    for (int i = 1; i < NTmDly; i++) begin
      tm_r[i] <= tm_r[i-1];
    end

    bd_s10_r  <= bd_full[9:0];
    c_s10_r   <= c_s9_r;

    v_s11_r   <= 24'(bd_s10_r) * 24'(EScale);
    bd_s11_r  <= bd_s10_r;
    c_s11_r   <= c_s10_r;

    eq_s12_r  <= eq_prod[27:24];
    v_s12_r   <= v_s11_r;
    bd_s12_r  <= bd_s11_r;
    c_s12_r   <= c_s11_r;

    er_s13_r  <= er_full[19:0];
    eq_s13_r  <= eq_s12_r;
    bd_s13_r  <= bd_s12_r;
    c_s13_r   <= c_s12_r;

    e_s14_r   <= eq_s13_r + 4'(er_s13_r >= 20'(EDen));
    bd_s14_r  <= bd_s13_r;
    c_s14_r   <= c_s13_r;

    out_year         <= year_nxt;
    out_month        <= mon_nxt;
    out_day_of_month <= dom_nxt;
    out_hour         <= tm_r[NTmDly-1].hour;
    out_minute       <= tm_r[NTmDly-1].minute;
    out_second       <= tm_r[NTmDly-1].second;
  end

  assign out_valid = vld_r[NStg-1];

endmodule

### bench/tb_unix_seconds_to_calendar.sv
// Testbench for the seconds-to-calendar pipeline: directed dates, random timestamps, day sweeps.
module tb_unix_seconds_to_calendar;
  import usc_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned LastDay = 49710;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_unix_seconds = 32'd0;
  logic        out_valid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  calendar_t   pending_dates[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on = 1'b1;

  unix_seconds_to_calendar uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_unix_seconds  (in_unix_seconds),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Gregorian date by the Julian-day method, every ratio as an exact integer quotient.
  function automatic calendar_t calendar_of_seconds(input logic [31:0] secs);
    longint unsigned days, tod, z, alpha, a, b, c, d, e, m;
    calendar_t date;
    days  = secs / SecsPerDay;
    tod   = secs % SecsPerDay;
    z     = days + EpochDay;
    alpha = (4 * z - AlphaNum) / AlphaDen;
    a     = z + 1 + alpha - alpha / 4;
    b     = a + 1524;
    c     = (20 * b - CSub) / CDen;
    d     = (1461 * c) / 4;
    e     = (EScale * (b - d)) / EDen;
    m     = (e < 14) ? e - 1 : e - 13;
    date.day_of_month = 5'(b - d - (EDen * e) / EScale);
    date.month        = 4'(m);
    date.year         = 12'((m > 2) ? c - YearOffsetLate : c - YearOffsetEarly);
    date.hour         = 5'(tod / SecsPerHour);
    date.minute       = 6'((tod / SecsPerMin) % 60);
    date.second       = 6'(tod % SecsPerMin);
    return date;
  endfunction

  task automatic report_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Request acceptance, result checking and the stall watchdog, all on the pre-edge values.
  always @(posedge clk) begin
    calendar_t want;
    if (rst_n && start && !busy) begin
      pending_dates.push_back(calendar_of_seconds(in_unix_seconds));
    end
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: result with no request outstanding, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $time, out_year, out_month, out_day_of_month, out_hour, out_minute,
                 out_second);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        report_field("year", want.year, out_year);
        report_field("month", want.month, out_month);
        report_field("day_of_month", want.day_of_month, out_day_of_month);
        report_field("hour", want.hour, out_hour);
        report_field("minute", want.minute, out_minute);
        report_field("second", want.second, out_second);
      end
    end
    if ((rst_n && start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Holds start high until the request is taken; start is lowered by an idle gap and after the last test.
  task automatic send_request(input logic [31:0] secs);
    start <= 1'b1;
    in_unix_seconds <= secs;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_idle();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_timestamp();
    longint unsigned total, offset;
    logic [31:0] secs;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: secs = $urandom();
      4, 5, 6: begin
        total = $urandom_range(0, LastDay);
        total = total * SecsPerDay;
        case ($urandom_range(0, 2))
          0:       offset = 0;
          1:       offset = SecsPerDay - 1;
          default: offset = $urandom_range(0, SecsPerDay - 1);
        endcase
        total = total + offset;
        if (total > 64'hFFFF_FFFF) total = total - SecsPerDay;
        secs = total[31:0];
      end
      7:       secs = $urandom_range(0, 5000000);
      8:       secs = 32'hFFFF_FFFF - $urandom_range(0, 5000000);
      default: secs = $urandom() >> $urandom_range(0, 31);
    endcase
    return secs;
  endfunction

  task automatic test_directed_dates();
    logic [31:0] marks[] = '{
      32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000, 32'd68169600, 32'd946684799, 32'd946684800,
      32'd951782400, 32'd951868800, 32'd2147483647, 32'd2147483648, 32'd4107542399,
      32'd4107542400, 32'hAAAA_AAAA, 32'h5555_5555
    };
    foreach (marks[i]) begin
      send_request(marks[i]);
      maybe_idle();
    end
  endtask

  task automatic test_random_timestamps(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      // Idle gaps come and go in blocks so that some stretches run without any.
      if (i % 64 == 0) gaps_on = $urandom_range(0, 2) != 0;
      send_request(pick_timestamp());
      maybe_idle();
    end
  endtask

  // Last second of each day followed by the next midnight, over random runs of days that can cross month and year ends.
  task automatic test_consecutive_days(input int unsigned sweeps, input int unsigned span);
    longint unsigned first_day, midnight;
    for (int unsigned s = 0; s < sweeps; s++) begin
      first_day = $urandom_range(1, LastDay - span - 1);
      gaps_on = s[0];
      for (int unsigned k = 0; k < span; k++) begin
        midnight = (first_day + k) * SecsPerDay;
        send_request(32'(midnight - 1));
        maybe_idle();
        send_request(32'(midnight));
        maybe_idle();
      end
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    gaps_on = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      send_request(pick_timestamp());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_dates();
    test_random_timestamps(900);
    test_consecutive_days(5, 40);
    test_back_to_back(240);
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
